// File: design/assert_macros.svh
// Assertion macros used by the formatter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: design/ipv6fmt_pkg.sv
// Shared types, codes and helper functions for the IPv6 text formatter.
package ipv6fmt_pkg;
	localparam int unsigned NumFields = 8;
	localparam int unsigned FieldW    = 16;

	typedef logic [2:0] op_t;
	localparam op_t OpCompressed = 3'd0;
	localparam op_t OpNetwork    = 3'd1;
	localparam op_t OpPrefix     = 3'd2;
	localparam op_t OpNetmask    = 3'd3;
	localparam op_t OpCanonical  = 3'd4;

	localparam logic [6:0] ChColon = 7'h3a;
	localparam logic [6:0] ChDot   = 7'h2e;
	localparam logic [6:0] ChSlash = 7'h2f;
	localparam logic [6:0] ChZero  = 7'h30;

	// Analysis result handed from the zero-run scanner to the emitter.
	typedef struct packed {
		logic       has_run;
		logic [2:0] run_pos;
		logic [3:0] run_end;
		logic       v4;
	} plan_t;

	function automatic logic [6:0] hex_char(input logic [3:0] d);
		hex_char = (d < 4'd10) ? (ChZero + {3'd0, d}) : (7'h57 + {3'd0, d});
	endfunction

	function automatic logic [6:0] dec_char(input logic [3:0] d);
		dec_char = ChZero + {3'd0, d};
	endfunction
endpackage

// File: design/ipv6fmt_scan.sv
// Zero-run scanner: one field per cycle, finds the longest zero run.
module ipv6fmt_scan (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [127:0]            fields,
	output logic                    done,
	output ipv6fmt_pkg::plan_t      plan
);
	import ipv6fmt_pkg::*;

	logic       busy_q;
	logic [3:0] k_q;
	logic [2:0] cur_pos_q, best_pos_q;
	logic [3:0] cur_len_q, best_len_q;
	logic [15:0] fld;
	logic [3:0] nlen;
	logic [3:0] blen;
	logic [15:0] f4, f5, f7;

	assign fld = fields[127 - 16*k_q[2:0] -: 16];
	assign nlen = cur_len_q + 4'd1;
	assign f4 = fields[63:48];
	assign f5 = fields[47:32];
	assign f7 = fields[15:0];

	// Step through the fields, tracking the current and best zero runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= '0;
				cur_len_q <= '0;
				best_len_q <= '0;
				best_pos_q <= '0;
				cur_pos_q <= '0;
			end else if (busy_q) begin
				if (fld == 16'd0) begin
					if (cur_len_q == 4'd0) cur_pos_q <= k_q[2:0];
					cur_len_q <= nlen;
					if (nlen > best_len_q) begin
						best_len_q <= nlen;
						best_pos_q <= (cur_len_q == 4'd0) ? k_q[2:0] : cur_pos_q;
					end
				end else begin
					cur_len_q <= '0;
				end
				k_q <= k_q + 4'd1;
				if (k_q == 4'd7) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Classify the best run, including the IPv4 tail cases.
	always_comb begin
		plan.has_run = best_len_q >= 4'd2;
		plan.run_pos = best_pos_q;
		plan.v4 = 1'b0;
		if (plan.has_run && best_pos_q == 3'd0) begin
			if (best_len_q == 4'd6) plan.v4 = 1'b1;
			else if (best_len_q == 4'd7 && f7 != 16'd1) plan.v4 = 1'b1;
			else if (best_len_q == 4'd5 && f5 == 16'hffff) plan.v4 = 1'b1;
			else if (best_len_q == 4'd4 && f4 == 16'hffff && f5 == 16'd0) plan.v4 = 1'b1;
		end
		blen = (plan.v4 && best_len_q == 4'd7) ? 4'd6 : best_len_q;
		plan.run_end = {1'b0, best_pos_q} + blen;
	end
endmodule

// File: design/ipv6_address_text_formatter.sv
// Top level: IPv6 address text formatter, emits the text one character at a time.
// The first character follows acceptance once the zero scan of all eight fields is done;
// dropped leading zeros in the first field and output stalls delay it further.
// A new address is taken only once the last character is out; a dropped leading zero
// still uses an emit slot, and a decimal byte shows only its significant digits.
// Reset: arst_n clears the sequencer and the output valid; payload is not reset.
`include "assert_macros.svh"
module ipv6_address_text_formatter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ipv6fmt_pkg::op_t     op,
	input  logic [63:0]          addr_high,
	input  logic [63:0]          addr_low,
	input  logic [7:0]           prefix_len,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [6:0]           char_code,
	output logic                 last_char
);
	import ipv6fmt_pkg::*;

	typedef enum logic [2:0] {
		StIdle, StScan, StField, StV4, StSuffix
	} state_t;

	state_t      state_q;
	logic [127:0] f_q;
	op_t         op_q;
	logic [7:0]  plen_q;
	plan_t       plan;
	logic        scan_start, scan_done;
	logic [3:0]  k_q;
	logic [2:0]  sub_q;
	logic        started_q;
	logic [127:0] mask;
	logic [7:0]  p;
	logic        take;
	logic        out_free;

	assign in_stall = (state_q != StIdle);
	assign take = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign p = (prefix_len > 8'd128) ? 8'd128 : prefix_len;
	assign mask = (p == 8'd0) ? 128'd0 : ~(128'd0) << (8'd128 - p);
	assign scan_start = take;

	ipv6fmt_scan u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .fields(f_q),
		.done(scan_done), .plan(plan)
	);

	// Current field, its digits and decimal split of the tail bytes.
	logic [15:0] fld;
	logic [3:0]  hexd;
	logic [7:0]  dbyte;
	logic [3:0]  d100, d10, d1;
	logic [7:0]  rem100;
	logic [1:0]  ndig;
	logic        canon;

	assign fld = f_q[127 - 16*k_q[2:0] -: 16];
	assign canon = (op_q == OpCanonical);

	// Pick the byte shown by the IPv4 tail or the suffix.
	always_comb begin
		if (state_q == StSuffix) dbyte = plen_q;
		else dbyte = f_q[31 - 8*k_q[1:0] -: 8];
		d100 = (dbyte >= 8'd200) ? 4'd2 : (dbyte >= 8'd100) ? 4'd1 : 4'd0;
		rem100 = dbyte - 8'(d100 * 8'd100);
		d10 = 4'(({8'd0, rem100} * 16'd205) >> 11);
		d1 = 4'(rem100 - 8'(d10 * 8'd10));
		ndig = (dbyte >= 8'd100) ? 2'd3 : (dbyte >= 8'd10) ? 2'd2 : 2'd1;
		hexd = fld[15 - 4*sub_q[1:0] -: 4];
	end

	// Sequence: scan, then emit at most one character per free output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid <= 1'b0;
			k_q <= '0;
			sub_q <= '0;
			started_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (take) begin
						op_q <= op;
						plen_q <= prefix_len;
						if (op == OpNetwork || op == OpPrefix)
							f_q <= {addr_high, addr_low} & mask;
						else if (op == OpNetmask) f_q <= mask;
						else f_q <= {addr_high, addr_low};
						state_q <= StScan;
					end
				end
				StScan: begin
					if (scan_done) begin
						state_q <= StField;
						k_q <= '0;
						sub_q <= '0;
						started_q <= 1'b0;
					end
				end
				StField: begin
					if (out_free) begin
						out_valid <= 1'b1;
						last_char <= 1'b0;
						if (canon) begin
							// sub 0 is a separator for every field but the first
							if (sub_q == 3'd0 && k_q != 4'd0) begin
								char_code <= ChColon;
								sub_q <= 3'd1;
							end else begin
								char_code <= hex_char(fld[15 - 4*(sub_q == 3'd0 ? 2'd0
									: 2'(sub_q - 3'd1)) -: 4]);
								if (sub_q == 3'd4) begin
									sub_q <= '0;
									k_q <= k_q + 4'd1;
									if (k_q == 4'd7) begin
										last_char <= 1'b1;
										state_q <= StIdle;
									end
								end else if (k_q == 4'd0 && sub_q == 3'd0) begin
									sub_q <= 3'd2;
								end else begin
									sub_q <= sub_q + 3'd1;
								end
							end
						end else if (plan.has_run && k_q == {1'b0, plan.run_pos}
								&& sub_q != 3'd7) begin
							// first ':' of "::"
							char_code <= ChColon;
							sub_q <= 3'd7;
						end else if (sub_q == 3'd7) begin
							char_code <= ChColon;
							sub_q <= '0;
							k_q <= plan.run_end;
							if (plan.run_end == 4'd8) begin
								if (op_q == OpPrefix) state_q <= StSuffix;
								else begin
									last_char <= 1'b1;
									state_q <= StIdle;
								end
								sub_q <= '0;
							end else if (plan.v4 && plan.run_end == 4'd6) begin
								state_q <= StV4;
								k_q <= '0;
							end
						end else if (sub_q == 3'd0 && k_q != 4'd0 && !started_q
								&& !(plan.has_run && k_q == plan.run_end)) begin
							char_code <= ChColon;
							started_q <= 1'b1;
						end else begin
							// skip leading zero digits
							if (hexd == 4'd0 && sub_q != 3'd3 && !(sub_q != 3'd0
									&& started_q && fld[15 -: 4] != 4'd0) &&
									(fld >> (4*(3 - sub_q[1:0]))) == 16'd0) begin
								out_valid <= 1'b0;
								sub_q <= sub_q + 3'd1;
								started_q <= 1'b1;
							end else begin
								char_code <= hex_char(hexd);
								started_q <= 1'b1;
								if (sub_q == 3'd3) begin
									sub_q <= '0;
									started_q <= 1'b0;
									k_q <= k_q + 4'd1;
									if (k_q == 4'd7) begin
										if (op_q == OpPrefix) state_q <= StSuffix;
										else begin
											last_char <= 1'b1;
											state_q <= StIdle;
										end
									end else if (plan.v4 && k_q == 4'd5) begin
										// hand the last two fields to the dotted tail
										state_q <= StV4;
										k_q <= '0;
									end
								end else sub_q <= sub_q + 3'd1;
							end
						end
					end
				end
				StV4, StSuffix: begin
					if (out_free) begin
						out_valid <= 1'b1;
						last_char <= 1'b0;
						// sub: 0 separator, 1..3 digits
						if (sub_q == 3'd0) begin
							if (state_q == StSuffix) char_code <= ChSlash;
							else if (k_q != 4'd0) char_code <= ChDot;
							else if (plan.run_end != 4'd6) char_code <= ChColon;
							else out_valid <= 1'b0;
							sub_q <= 3'd4 - {1'b0, ndig};
						end else begin
							char_code <= (sub_q == 3'd1) ? dec_char(d100)
								: (sub_q == 3'd2) ? dec_char(d10) : dec_char(d1);
							if (sub_q == 3'd3) begin
								sub_q <= '0;
								k_q <= k_q + 4'd1;
								if (state_q == StSuffix || k_q == 4'd3) begin
									if (state_q == StV4 && op_q == OpPrefix) begin
										state_q <= StSuffix;
									end else begin
										last_char <= 1'b1;
										state_q <= StIdle;
									end
								end
							end else sub_q <= sub_q + 3'd1;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`ASSERT_NEXT(a_busy_stall, clk, arst_n, take, in_stall, "accepted item must block input")
	`ASSERT_CLK(a_last_idle, clk, arst_n, (out_valid && last_char && $rose(out_valid)) |-> (state_q == StIdle), "last char must end the sequence")
	`ASSERT_CLK(a_no_out_idle_scan, clk, arst_n, (state_q == StScan) |-> !scan_start, "scan restarted while scanning")
endmodule
